### rtl/core/dds_pkg.sv
`default_nettype none

package dds_pkg;

	// Fixed geometry and scaling of the chassis.
	localparam logic [11:0] HALF_TRACK_Q10 = 12'd154;
	localparam logic [15:0] PULSE_SCALE_Q8 = 16'd4096;
	localparam logic [3:0]  TIMEOUT_TICKS  = 4'd8;
	localparam int          BRAKE_SLEW_Q8  = 6400;
	localparam int          LEVEL_MAX      = 25600;
	localparam int          TARGET_MAX     = 262143;
	localparam int          TARGET_MIN     = -262144;

	// Division by ten is a multiply by ceil(2^35 / 10) and a shift by 35,
	// exact for any unsigned operand below 2^32.
	localparam logic [31:0] RECIP_TEN      = 32'hCCCC_CCCD;
	localparam int          RECIP_SHIFT    = 35;
	// Bias that keeps the EMA dividend positive; it is ten times 2^26.
	localparam int          EMA_BIAS_LOG2  = 26;

	// Configuration register indexes.
	localparam logic [2:0] CFG_AUTO_MODE   = 3'd0;
	localparam logic [2:0] CFG_RAMP_UP     = 3'd1;
	localparam logic [2:0] CFG_RAMP_DOWN   = 3'd2;
	localparam logic [2:0] CFG_RAMP_TURN   = 3'd3;
	localparam logic [2:0] CFG_DEAD_LIN    = 3'd4;
	localparam logic [2:0] CFG_DEAD_TURN   = 3'd5;
	localparam logic [2:0] CFG_GAIN_P      = 3'd6;
	localparam logic [2:0] CFG_GAIN_D      = 3'd7;

	// Input operation codes.
	localparam logic OP_COMMAND = 1'b0;
	localparam logic OP_TICK    = 1'b1;

	// Datapath step issued by the controller in each cycle.
	typedef enum logic [3:0] {
		STEP_IDLE,
		STEP_STORE,
		STEP_RAMP,
		STEP_DEAD,
		STEP_MUL1,
		STEP_MUL2,
		STEP_TGT,
		STEP_EMAMUL,
		STEP_EMAUPD,
		STEP_BMUL,
		STEP_BUPD
	} step_t;

	typedef struct packed {
		step_t step;
		logic  capture;
		logic  load;
	} dds_cmd_t;

endpackage

`default_nettype wire

### rtl/core/dds_ctrl.sv
`default_nettype none

module dds_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	input  wire               operation,
	input  wire               out_stall,
	output logic              in_stall,
	output logic              out_valid,
	output dds_pkg::dds_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_HOLD
	} state_t;

	state_t         state_q;
	dds_pkg::step_t step_q;
	logic           out_valid_q;
	logic           capture;
	logic           load;

	assign in_stall  = (state_q != ST_IDLE);
	assign capture   = in_valid && (state_q == ST_IDLE);
	assign load      = (state_q == ST_HOLD) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.step    = (state_q == ST_RUN) ? step_q : dds_pkg::STEP_IDLE;
		cmd.capture = capture;
		cmd.load    = load;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= dds_pkg::STEP_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (capture) begin
						state_q <= ST_RUN;
						step_q  <= (operation == dds_pkg::OP_TICK) ?
							dds_pkg::STEP_RAMP : dds_pkg::STEP_STORE;
					end
				end
				ST_RUN: begin
					unique case (step_q)
						dds_pkg::STEP_RAMP:   step_q <= dds_pkg::STEP_DEAD;
						dds_pkg::STEP_DEAD:   step_q <= dds_pkg::STEP_MUL1;
						dds_pkg::STEP_MUL1:   step_q <= dds_pkg::STEP_MUL2;
						dds_pkg::STEP_MUL2:   step_q <= dds_pkg::STEP_TGT;
						dds_pkg::STEP_TGT:    step_q <= dds_pkg::STEP_EMAMUL;
						dds_pkg::STEP_EMAMUL: step_q <= dds_pkg::STEP_EMAUPD;
						dds_pkg::STEP_EMAUPD: step_q <= dds_pkg::STEP_BMUL;
						dds_pkg::STEP_BMUL:   step_q <= dds_pkg::STEP_BUPD;
						default: begin
							step_q  <= dds_pkg::STEP_IDLE;
							state_q <= ST_HOLD;
						end
					endcase
				end
				ST_HOLD: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/core/dds_dp.sv
`default_nettype none

module dds_dp (
	input  wire                      clk,
	input  wire                      arst_n,
	input  dds_pkg::dds_cmd_t        cmd,
	input  wire                      cfg_valid,
	input  wire  [2:0]               cfg_index,
	input  wire  [15:0]              cfg_data,
	input  wire                      operation,
	input  wire  signed [13:0]       cmd_linear,
	input  wire  signed [13:0]       cmd_angular,
	input  wire                      command_source,
	input  wire  signed [13:0]       yaw_correction,
	input  wire  signed [15:0]       pulse_left,
	input  wire  signed [15:0]       pulse_right,
	output logic                     accepted,
	output logic signed [18:0]       target_left,
	output logic signed [18:0]       target_right,
	output logic                     braking,
	output logic signed [7:0]        brake_drive_left,
	output logic signed [7:0]        brake_drive_right,
	output logic signed [23:0]       filtered_left,
	output logic signed [23:0]       filtered_right
);

	// Configuration registers.
	logic        auto_q;
	logic [9:0]  ramp_up_q;
	logic [9:0]  ramp_down_q;
	logic [10:0] ramp_turn_q;
	logic [7:0]  dead_lin_q;
	logic [7:0]  dead_turn_q;
	logic [15:0] gain_p_q;
	logic [15:0] gain_d_q;

	// Captured item.
	logic               op_q;
	logic signed [13:0] cmd_lin_q;
	logic signed [13:0] cmd_ang_q;
	logic               src_q;
	logic signed [13:0] yaw_q;
	logic signed [15:0] pulse_q [2];

	// Persistent state.
	logic signed [13:0] held_lin_q;
	logic signed [13:0] held_ang_q;
	logic [3:0]         tmo_q;
	logic signed [14:0] ramp_lin_q;
	logic signed [14:0] ramp_ang_q;
	logic signed [23:0] ema_q [2];
	logic               brake_on_q;
	logic signed [15:0] level_q [2];
	logic signed [25:0] last_err_q [2];
	logic               acc_q;

	// Work registers.
	logic signed [27:0] vt_q;
	logic signed [46:0] wp_q [2];
	logic signed [18:0] tgt_q [2];
	logic [29:0]        ema_y_q [2];
	logic [61:0]        ema_p_q [2];
	logic signed [24:0] err_q [2];
	logic               brk_q;
	logic signed [41:0] pterm_q [2];
	logic signed [43:0] dterm_q [2];
	logic signed [7:0]  drv_q [2];

	// Combinational step results.
	logic               zero_tgt;
	logic signed [16:0] tv;
	logic signed [16:0] tw;
	logic signed [16:0] dlin;
	logic signed [16:0] dang;
	logic signed [16:0] lim_up;
	logic signed [16:0] lim_dn;
	logic signed [16:0] lim_turn;
	logic signed [16:0] slin;
	logic signed [16:0] sang;
	logic signed [16:0] rl_next;
	logic signed [16:0] ra_next;
	logic               in_dead;
	logic signed [28:0] vc;
	logic signed [28:0] ws [2];
	logic signed [46:0] tsum [2];
	logic signed [18:0] tgt_c [2];
	logic signed [24:0] ema_d [2];
	logic signed [30:0] ema_x [2];
	logic signed [27:0] ema_c [2];
	logic               brk_c;
	logic signed [24:0] err_c [2];
	logic signed [44:0] bsum [2];
	logic signed [44:0] bwant [2];
	logic signed [44:0] bdiff [2];
	logic signed [44:0] bstep [2];
	logic signed [44:0] blvl [2];
	logic signed [15:0] lvl_c [2];
	logic signed [15:0] lvl_neg [2];
	logic signed [7:0]  drv_c [2];

	always_comb begin
		zero_tgt = auto_q && (tmo_q >= dds_pkg::TIMEOUT_TICKS);
		tv = zero_tgt ? 17'sd0 : 17'(held_lin_q);
		tw = (zero_tgt ? 17'sd0 : 17'(held_ang_q)) + 17'(yaw_q);
		dlin = tv - 17'(ramp_lin_q);
		dang = tw - 17'(ramp_ang_q);
		lim_up   = $signed({7'd0, ramp_up_q});
		lim_dn   = -$signed({7'd0, ramp_down_q});
		lim_turn = $signed({6'd0, ramp_turn_q});
		if (dlin > lim_up) begin
			slin = lim_up;
		end else if (dlin < lim_dn) begin
			slin = lim_dn;
		end else begin
			slin = dlin;
		end
		if (dang > lim_turn) begin
			sang = lim_turn;
		end else if (dang < -lim_turn) begin
			sang = -lim_turn;
		end else begin
			sang = dang;
		end
		rl_next = 17'(ramp_lin_q) + slin;
		ra_next = 17'(ramp_ang_q) + sang;
		in_dead = (17'(ramp_lin_q) <= $signed({9'd0, dead_lin_q}))
			&& (17'(ramp_lin_q) >= -$signed({9'd0, dead_lin_q}))
			&& (17'(ramp_ang_q) <= $signed({9'd0, dead_turn_q}))
			&& (17'(ramp_ang_q) >= -$signed({9'd0, dead_turn_q}));
		vc = 29'($signed({ramp_lin_q, 10'd0}));
		ws[0] = vc - 29'(vt_q);
		ws[1] = vc + 29'(vt_q);
		brk_c = 1'b1;
		for (int i = 0; i < 2; i++) begin
			// Round half up, then saturate to the target range.
			tsum[i] = (wp_q[i] + 47'sd524288) >>> 20;
			if (tsum[i] > 47'(dds_pkg::TARGET_MAX)) begin
				tgt_c[i] = 19'(dds_pkg::TARGET_MAX);
			end else if (tsum[i] < 47'(dds_pkg::TARGET_MIN)) begin
				tgt_c[i] = 19'(dds_pkg::TARGET_MIN);
			end else begin
				tgt_c[i] = 19'(tsum[i]);
			end
			ema_d[i] = 25'($signed({pulse_q[i], 8'd0})) - 25'(ema_q[i]);
			ema_x[i] = (31'(ema_d[i]) <<< 2) + 31'sd5
				+ (31'sd10 <<< dds_pkg::EMA_BIAS_LOG2);
			ema_c[i] = 28'(ema_q[i])
				+ $signed({1'b0, ema_p_q[i][dds_pkg::RECIP_SHIFT +: 27]})
				- (28'sd1 <<< dds_pkg::EMA_BIAS_LOG2);
			brk_c = brk_c && (tgt_q[i] < 19'sd128) && (tgt_q[i] > -19'sd128);
			err_c[i] = 25'(tgt_q[i]) - 25'($signed({pulse_q[i], 8'd0}));
			bsum[i]  = 45'(pterm_q[i]) + 45'(dterm_q[i]);
			bwant[i] = bsum[i] >>> 8;
			bdiff[i] = bwant[i] - 45'(level_q[i]);
			if (bdiff[i] > 45'(dds_pkg::BRAKE_SLEW_Q8)) begin
				bstep[i] = 45'(dds_pkg::BRAKE_SLEW_Q8);
			end else if (bdiff[i] < -45'(dds_pkg::BRAKE_SLEW_Q8)) begin
				bstep[i] = -45'(dds_pkg::BRAKE_SLEW_Q8);
			end else begin
				bstep[i] = bdiff[i];
			end
			blvl[i] = 45'(level_q[i]) + bstep[i];
			if (blvl[i] > 45'(dds_pkg::LEVEL_MAX)) begin
				lvl_c[i] = 16'(dds_pkg::LEVEL_MAX);
			end else if (blvl[i] < -45'(dds_pkg::LEVEL_MAX)) begin
				lvl_c[i] = -16'(dds_pkg::LEVEL_MAX);
			end else begin
				lvl_c[i] = 16'(blvl[i]);
			end
			lvl_neg[i] = -lvl_c[i];
			drv_c[i] = (lvl_c[i] >= 16'sd0) ? 8'(lvl_c[i] >>> 8) : -8'(lvl_neg[i] >>> 8);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_q      <= 1'b0;
			ramp_up_q   <= 10'd102;
			ramp_down_q <= 10'd307;
			ramp_turn_q <= 11'd768;
			dead_lin_q  <= 8'd20;
			dead_turn_q <= 8'd41;
			gain_p_q    <= 16'd2560;
			gain_d_q    <= 16'd77;
			held_lin_q  <= '0;
			held_ang_q  <= '0;
			tmo_q       <= '0;
			ramp_lin_q  <= '0;
			ramp_ang_q  <= '0;
			brake_on_q  <= 1'b0;
			acc_q       <= 1'b0;
			for (int i = 0; i < 2; i++) begin
				ema_q[i]      <= '0;
				level_q[i]    <= '0;
				last_err_q[i] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					dds_pkg::CFG_AUTO_MODE: auto_q      <= cfg_data[0];
					dds_pkg::CFG_RAMP_UP:   ramp_up_q   <= cfg_data[9:0];
					dds_pkg::CFG_RAMP_DOWN: ramp_down_q <= cfg_data[9:0];
					dds_pkg::CFG_RAMP_TURN: ramp_turn_q <= cfg_data[10:0];
					dds_pkg::CFG_DEAD_LIN:  dead_lin_q  <= cfg_data[7:0];
					dds_pkg::CFG_DEAD_TURN: dead_turn_q <= cfg_data[7:0];
					dds_pkg::CFG_GAIN_P:    gain_p_q    <= cfg_data;
					dds_pkg::CFG_GAIN_D:    gain_d_q    <= cfg_data;
					default: ;
				endcase
			end
			case (cmd.step)
				dds_pkg::STEP_STORE: begin
					if (src_q == auto_q) begin
						held_lin_q <= cmd_lin_q;
						held_ang_q <= cmd_ang_q;
						if (src_q) begin
							tmo_q <= '0;
						end
						acc_q <= 1'b1;
					end else begin
						acc_q <= 1'b0;
					end
				end
				dds_pkg::STEP_RAMP: begin
					ramp_lin_q <= 15'(rl_next);
					ramp_ang_q <= 15'(ra_next);
					if (auto_q && (tmo_q < dds_pkg::TIMEOUT_TICKS)) begin
						tmo_q <= tmo_q + 4'd1;
					end
				end
				dds_pkg::STEP_DEAD: begin
					if (in_dead) begin
						ramp_lin_q <= '0;
						ramp_ang_q <= '0;
					end
				end
				dds_pkg::STEP_EMAUPD: begin
					brake_on_q <= brk_c;
					for (int i = 0; i < 2; i++) begin
						ema_q[i] <= 24'(ema_c[i]);
						if (brk_c && !brake_on_q) begin
							last_err_q[i] <= 26'(err_c[i]);
							level_q[i]    <= '0;
						end
					end
				end
				dds_pkg::STEP_BUPD: begin
					if (brk_q) begin
						for (int i = 0; i < 2; i++) begin
							level_q[i]    <= lvl_c[i];
							last_err_q[i] <= 26'(err_q[i]);
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q       <= operation;
			cmd_lin_q  <= cmd_linear;
			cmd_ang_q  <= cmd_angular;
			src_q      <= command_source;
			yaw_q      <= yaw_correction;
			pulse_q[0] <= pulse_left;
			pulse_q[1] <= pulse_right;
		end
		case (cmd.step)
			dds_pkg::STEP_MUL1: begin
				vt_q <= 28'(ramp_ang_q) * 28'($signed({1'b0, dds_pkg::HALF_TRACK_Q10}));
			end
			dds_pkg::STEP_MUL2: begin
				for (int i = 0; i < 2; i++) begin
					wp_q[i] <= 47'(ws[i]) * 47'($signed({1'b0, dds_pkg::PULSE_SCALE_Q8}));
				end
			end
			dds_pkg::STEP_TGT: begin
				for (int i = 0; i < 2; i++) begin
					tgt_q[i]   <= tgt_c[i];
					ema_y_q[i] <= ema_x[i][29:0];
				end
			end
			dds_pkg::STEP_EMAMUL: begin
				for (int i = 0; i < 2; i++) begin
					ema_p_q[i] <= 62'(ema_y_q[i]) * 62'(dds_pkg::RECIP_TEN);
				end
			end
			dds_pkg::STEP_EMAUPD: begin
				brk_q <= brk_c;
				for (int i = 0; i < 2; i++) begin
					err_q[i] <= err_c[i];
				end
			end
			dds_pkg::STEP_BMUL: begin
				for (int i = 0; i < 2; i++) begin
					pterm_q[i] <= 42'($signed({1'b0, gain_p_q})) * 42'(err_q[i]);
					dterm_q[i] <= 44'($signed({1'b0, gain_d_q}))
						* (44'(err_q[i]) - 44'(last_err_q[i]));
				end
			end
			dds_pkg::STEP_BUPD: begin
				for (int i = 0; i < 2; i++) begin
					drv_q[i] <= brk_q ? drv_c[i] : 8'sd0;
				end
			end
			default: ;
		endcase
		if (cmd.load) begin
			if (op_q == dds_pkg::OP_TICK) begin
				accepted          <= 1'b0;
				target_left       <= tgt_q[0];
				target_right      <= tgt_q[1];
				braking           <= brk_q;
				brake_drive_left  <= drv_q[0];
				brake_drive_right <= drv_q[1];
				filtered_left     <= ema_q[0];
				filtered_right    <= ema_q[1];
			end else begin
				accepted          <= acc_q;
				target_left       <= '0;
				target_right      <= '0;
				braking           <= 1'b0;
				brake_drive_left  <= '0;
				brake_drive_right <= '0;
				filtered_left     <= '0;
				filtered_right    <= '0;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/diff_drive_setpoint_brake.sv
`default_nettype none

// Setpoint and brake block for a differential-drive chassis. A command item
// stores a linear and an angular velocity when its source matches the mode;
// a tick item ramps the setpoint, converts it to wheel pulse targets, filters
// the measured pulses and runs a PD brake near standstill. The block works on
// one item at a time. The controller steps each item through a fixed
// sequence, and every multiply in it has a register of its own. A command
// runs the store step; a tick runs the ramp, deadband, wheel-speed multiply,
// target, filter multiply, filter update, brake multiply and brake update steps.
// The result then goes into the output register once that register is empty
// or being read, and out_valid is set. The next item can be accepted in the
// cycle after that load, so an unread result does not hold up the work on
// the next item. Configuration writes are always taken (ready is tied high)
// and must only be issued while no item is in flight.
module diff_drive_setpoint_brake (
	input  wire                clk,
	input  wire                arst_n,
	// Input channel: a beat moves at a rising edge with in_valid high and
	// in_stall low.
	input  wire                in_valid,
	output logic               in_stall,
	input  wire                operation,
	input  wire  signed [13:0] cmd_linear,
	input  wire  signed [13:0] cmd_angular,
	input  wire                command_source,
	input  wire  signed [13:0] yaw_correction,
	input  wire  signed [15:0] pulse_left,
	input  wire  signed [15:0] pulse_right,
	// Output channel: a beat moves at a rising edge with out_valid high and
	// out_stall low.
	output logic               out_valid,
	input  wire                out_stall,
	output logic               accepted,
	output logic signed [18:0] target_left,
	output logic signed [18:0] target_right,
	output logic               braking,
	output logic signed [7:0]  brake_drive_left,
	output logic signed [7:0]  brake_drive_right,
	output logic signed [23:0] filtered_left,
	output logic signed [23:0] filtered_right,
	// Configuration write channel.
	input  wire                cfg_valid,
	output logic               cfg_ready,
	input  wire  [2:0]         cfg_index,
	input  wire  [15:0]        cfg_data
);

	dds_pkg::dds_cmd_t cmd;

	// Register writes are stored at the clock edge that takes them, so the port never pushes back.
	assign cfg_ready = 1'b1;

	// The controller sequences the steps of each item and owns both
	// handshakes.
	dds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.operation (operation),
		.out_stall (out_stall),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	// The datapath holds configuration, state, the multipliers and the
	// output register.
	dds_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.cfg_valid         (cfg_valid && cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.operation         (operation),
		.cmd_linear        (cmd_linear),
		.cmd_angular       (cmd_angular),
		.command_source    (command_source),
		.yaw_correction    (yaw_correction),
		.pulse_left        (pulse_left),
		.pulse_right       (pulse_right),
		.accepted          (accepted),
		.target_left       (target_left),
		.target_right      (target_right),
		.braking           (braking),
		.brake_drive_left  (brake_drive_left),
		.brake_drive_right (brake_drive_right),
		.filtered_left     (filtered_left),
		.filtered_right    (filtered_right)
	);

endmodule

`default_nettype wire

### tb/sv/tb_diff_drive_setpoint_brake.sv
`timescale 1ns / 1ps

module tb_diff_drive_setpoint_brake;

	// One input beat as the driver presents it.
	typedef struct {
		logic               op;
		logic signed [13:0] lin;
		logic signed [13:0] ang;
		logic               src;
		logic signed [13:0] yaw;
		logic signed [15:0] pl;
		logic signed [15:0] pr;
	} drive_item_t;

	// One output beat as the block should present it.
	typedef struct {
		logic               acc;
		logic signed [18:0] tl;
		logic signed [18:0] tr;
		logic               brk;
		logic signed [7:0]  dl;
		logic signed [7:0]  dr;
		logic signed [23:0] fl;
		logic signed [23:0] fr;
	} wheel_result_t;

	localparam longint CYCLE_LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic operation = 1'b0;
	logic signed [13:0] cmd_linear = '0;
	logic signed [13:0] cmd_angular = '0;
	logic command_source = 1'b0;
	logic signed [13:0] yaw_correction = '0;
	logic signed [15:0] pulse_left = '0;
	logic signed [15:0] pulse_right = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic accepted;
	logic signed [18:0] target_left, target_right;
	logic braking;
	logic signed [7:0] brake_drive_left, brake_drive_right;
	logic signed [23:0] filtered_left, filtered_right;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	diff_drive_setpoint_brake uut (.*);

	always #5 clk = ~clk;

	// Pending beats for the driver and results the monitor still waits for.
	drive_item_t   pending_items[$];
	wheel_result_t expected_results[$];
	int            errors = 0;
	longint        cycles = 0;
	bit            driver_hold = 1'b0;

	// Predictor copy of the configuration registers.
	longint m_auto, m_up, m_down, m_turn, m_dbl, m_dbt, m_kp, m_kd;
	// Predictor copy of the block state.
	longint hold_lin, hold_ang, tmo, ramp_lin, ramp_ang, ema_l, ema_r;
	bit     brake_armed;
	longint level_q8[2], last_err[2];

	function automatic longint fdiv(longint a, longint d);
		longint q;
		q = a / d;
		if ((a % d) != 0 && a < 0) q -= 1;
		return q;
	endfunction

	function automatic longint clip(longint x, longint lo, longint hi);
		return x < lo ? lo : (x > hi ? hi : x);
	endfunction

	function automatic longint pulse_target(longint vq20);
		return clip(fdiv(vq20 * longint'(dds_pkg::PULSE_SCALE_Q8) + (64'sd1 <<< 19),
			64'sd1 <<< 20), longint'(dds_pkg::TARGET_MIN), longint'(dds_pkg::TARGET_MAX));
	endfunction

	function automatic longint brake_step(int w, longint err);
		longint want, d;
		want = fdiv(m_kp * err + m_kd * (err - last_err[w]), 256);
		d = clip(want - level_q8[w], -longint'(dds_pkg::BRAKE_SLEW_Q8),
			longint'(dds_pkg::BRAKE_SLEW_Q8));
		last_err[w] = err;
		level_q8[w] = clip(level_q8[w] + d, -longint'(dds_pkg::LEVEL_MAX),
			longint'(dds_pkg::LEVEL_MAX));
		return level_q8[w] >= 0 ? level_q8[w] / 256 : -((-level_q8[w]) / 256);
	endfunction

	// Works out the result of one accepted beat and advances the state.
	function automatic wheel_result_t predict_wheels(drive_item_t it);
		wheel_result_t r;
		longint tv, tw, vc, vt, tl, tr, pl, pr, dl, dr;
		bit brk;
		r = '{default: '0};
		if (it.op == dds_pkg::OP_COMMAND) begin
			if (longint'(it.src) != m_auto) return r;
			if (it.src) tmo = 0;
			hold_lin = longint'(it.lin);
			hold_ang = longint'(it.ang);
			r.acc = 1'b1;
			return r;
		end
		tv = hold_lin;
		tw = hold_ang;
		if (m_auto != 0) begin
			if (tmo >= longint'(dds_pkg::TIMEOUT_TICKS)) begin
				tv = 0;
				tw = 0;
			end else tmo = tmo + 1;
		end
		tw += longint'(it.yaw);
		ramp_lin += clip(tv - ramp_lin, -m_down, m_up);
		ramp_ang += clip(tw - ramp_ang, -m_turn, m_turn);
		if (ramp_lin <= m_dbl && ramp_lin >= -m_dbl && ramp_ang <= m_dbt && ramp_ang >= -m_dbt) begin
			ramp_lin = 0;
			ramp_ang = 0;
		end
		vc = ramp_lin * 1024;
		vt = ramp_ang * longint'(dds_pkg::HALF_TRACK_Q10);
		tl = pulse_target(vc - vt);
		tr = pulse_target(vc + vt);
		pl = longint'(it.pl);
		pr = longint'(it.pr);
		ema_l = ema_l + fdiv(4 * (pl * 256 - ema_l) + 5, 10);
		ema_r = ema_r + fdiv(4 * (pr * 256 - ema_r) + 5, 10);
		dl = 0;
		dr = 0;
		brk = tl < 128 && tl > -128 && tr < 128 && tr > -128;
		if (brk) begin
			// Entering the brake starts from rest with no derivative kick.
			if (!brake_armed) begin
				last_err[0] = tl - pl * 256;
				last_err[1] = tr - pr * 256;
				level_q8[0] = 0;
				level_q8[1] = 0;
				brake_armed = 1'b1;
			end
			dl = brake_step(0, tl - pl * 256);
			dr = brake_step(1, tr - pr * 256);
		end else brake_armed = 1'b0;
		r.tl = 19'(tl);
		r.tr = 19'(tr);
		r.brk = brk;
		r.dl = 8'(dl);
		r.dr = 8'(dr);
		r.fl = 24'(ema_l);
		r.fr = 24'(ema_r);
		return r;
	endfunction

	// Driver: one beat at a time from the queue, with a random gap after each.
	int gap_left = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_results.push_back(predict_wheels(pending_items.pop_front()));
				in_valid <= 1'b0;
				gap_left <= ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 12));
			end else if (in_valid) begin
				// Hold the stalled beat as it is.
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
			end else if (!driver_hold && pending_items.size() != 0) begin
				in_valid <= 1'b1;
				operation <= pending_items[0].op;
				cmd_linear <= pending_items[0].lin;
				cmd_angular <= pending_items[0].ang;
				command_source <= pending_items[0].src;
				yaw_correction <= pending_items[0].yaw;
				pulse_left <= pending_items[0].pl;
				pulse_right <= pending_items[0].pr;
			end
		end
	end

	// Monitor: random stall per result and a field-by-field compare.
	int stall_left = 0;
	always @(posedge clk) begin
		wheel_result_t e;
		int draw;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result beat with nothing expected", $realtime);
					errors++;
				end else begin
					e = expected_results.pop_front();
					if (e.acc !== accepted) begin
						$display("%0t: accepted exp %0d got %0d", $realtime, e.acc, accepted);
						errors++;
					end
					if (e.tl !== target_left || e.tr !== target_right) begin
						$display("%0t: targets exp %0d %0d got %0d %0d", $realtime,
							e.tl, e.tr, target_left, target_right);
						errors++;
					end
					if (e.brk !== braking || e.dl !== brake_drive_left
							|| e.dr !== brake_drive_right) begin
						$display("%0t: brake exp %0d %0d %0d got %0d %0d %0d", $realtime,
							e.brk, e.dl, e.dr, braking, brake_drive_left, brake_drive_right);
						errors++;
					end
					if (e.fl !== filtered_left || e.fr !== filtered_right) begin
						$display("%0t: filtered exp %0d %0d got %0d %0d", $realtime,
							e.fl, e.fr, filtered_left, filtered_right);
						errors++;
					end
				end
				draw = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 12));
				out_stall <= (draw > 0);
				stall_left <= (draw > 0) ? draw - 1 : 0;
			end else if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left <= stall_left - 1;
			end else out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_diff_drive_setpoint_brake: errors");
			$finish;
		end
	end

	function automatic drive_item_t cmd_item(logic src, int lin, int ang);
		drive_item_t it;
		it = '{default: '0};
		it.op = dds_pkg::OP_COMMAND;
		it.src = src;
		it.lin = 14'(lin);
		it.ang = 14'(ang);
		it.yaw = 14'($urandom);
		it.pl = 16'($urandom);
		it.pr = 16'($urandom);
		return it;
	endfunction

	function automatic drive_item_t tick_item(int yaw, int pl, int pr);
		drive_item_t it;
		it = cmd_item(1'b0, int'($urandom), int'($urandom));
		it.op = dds_pkg::OP_TICK;
		it.yaw = 14'(yaw);
		it.pl = 16'(pl);
		it.pr = 16'(pr);
		return it;
	endfunction

	// Waits until the block has delivered everything and has drained fully.
	task automatic drain();
		while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	// Leaves the write channel valid so that writes can follow back to back.
	task automatic write_reg(logic [2:0] idx, int val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 16'(val);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			dds_pkg::CFG_AUTO_MODE: m_auto = longint'(val & 1);
			dds_pkg::CFG_RAMP_UP:   m_up = longint'(val & 'h3FF);
			dds_pkg::CFG_RAMP_DOWN: m_down = longint'(val & 'h3FF);
			dds_pkg::CFG_RAMP_TURN: m_turn = longint'(val & 'h7FF);
			dds_pkg::CFG_DEAD_LIN:  m_dbl = longint'(val & 'hFF);
			dds_pkg::CFG_DEAD_TURN: m_dbt = longint'(val & 'hFF);
			dds_pkg::CFG_GAIN_P:    m_kp = longint'(val & 'hFFFF);
			dds_pkg::CFG_GAIN_D:    m_kd = longint'(val & 'hFFFF);
			default: ;
		endcase
	endtask

	// Closes a run of register writes.
	task automatic end_writes();
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly small pulses so the brake region is reached, with some full range.
	function automatic int rand_pulse();
		return $urandom_range(0, 3) == 0 ? int'($signed(16'($urandom)))
			: int'($urandom_range(0, 40)) - 20;
	endfunction

	task automatic random_phase(int count);
		int k, mode_src;
		for (k = 0; k < count; k++) begin
			if ($urandom_range(0, 4) == 0) begin
				// Mostly the source that matches the mode, now and then the other.
				mode_src = ($urandom_range(0, 5) == 0) ? int'(m_auto == 0) : int'(m_auto);
				pending_items.push_back(cmd_item(1'(mode_src),
					$urandom_range(0, 3) == 0 ? int'($signed(14'($urandom)))
						: int'($urandom_range(0, 600)) - 300,
					$urandom_range(0, 3) == 0 ? int'($signed(14'($urandom)))
						: int'($urandom_range(0, 600)) - 300));
			end else
				pending_items.push_back(tick_item(
					$urandom_range(0, 4) == 0 ? int'($signed(14'($urandom)))
						: int'($urandom_range(0, 80)) - 40,
					rand_pulse(), rand_pulse()));
		end
		drain();
	endtask

	initial begin
		m_auto = 0; m_up = 102; m_down = 307; m_turn = 768;
		m_dbl = 20; m_dbt = 41; m_kp = 2560; m_kd = 77;
		hold_lin = 0; hold_ang = 0; tmo = 0; ramp_lin = 0; ramp_ang = 0;
		ema_l = 0; ema_r = 0; brake_armed = 1'b0;
		level_q8 = '{0, 0};
		last_err = '{0, 0};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, a rejected command, the brake entry and deadband.
		pending_items.push_back(tick_item(0, 0, 0));
		pending_items.push_back(tick_item(0, 32767, -32768));
		pending_items.push_back(cmd_item(1'b1, 8191, -8192));
		pending_items.push_back(cmd_item(1'b0, 8191, -8192));
		pending_items.push_back(tick_item(8191, 100, -100));
		pending_items.push_back(tick_item(-8192, -32768, 32767));
		pending_items.push_back(cmd_item(1'b0, -8192, 8191));
		repeat (4) pending_items.push_back(tick_item(0, 5, -5));
		pending_items.push_back(cmd_item(1'b0, 10, 10));
		repeat (4) pending_items.push_back(tick_item(0, -3, 7));
		drain();

		// Auto mode with extreme limits, then the timeout after eight ticks.
		write_reg(dds_pkg::CFG_AUTO_MODE, 1);
		write_reg(dds_pkg::CFG_RAMP_UP, 1023);
		write_reg(dds_pkg::CFG_RAMP_DOWN, 1023);
		write_reg(dds_pkg::CFG_RAMP_TURN, 2047);
		write_reg(dds_pkg::CFG_DEAD_LIN, 255);
		write_reg(dds_pkg::CFG_DEAD_TURN, 255);
		write_reg(dds_pkg::CFG_GAIN_P, 65535);
		write_reg(dds_pkg::CFG_GAIN_D, 65535);
		end_writes();
		pending_items.push_back(cmd_item(1'b1, 8191, 8191));
		pending_items.push_back(cmd_item(1'b0, 1, 1));
		repeat (11) pending_items.push_back(tick_item(0, 32767, 32767));
		drain();
		random_phase(300);

		// Hold the sender in mid-stream until every result has come back.
		repeat (6) pending_items.push_back(tick_item(0, 0, 0));
		while (pending_items.size() > 3) @(posedge clk);
		driver_hold = 1'b1;
		while (in_valid || expected_results.size() != 0) @(posedge clk);
		repeat (5) @(posedge clk);
		driver_hold = 1'b0;
		drain();

		write_reg(dds_pkg::CFG_AUTO_MODE, 0);
		write_reg(dds_pkg::CFG_RAMP_UP, 0);
		write_reg(dds_pkg::CFG_RAMP_DOWN, 0);
		write_reg(dds_pkg::CFG_RAMP_TURN, 0);
		write_reg(dds_pkg::CFG_DEAD_LIN, 0);
		write_reg(dds_pkg::CFG_DEAD_TURN, 0);
		write_reg(dds_pkg::CFG_GAIN_P, 0);
		write_reg(dds_pkg::CFG_GAIN_D, 0);
		end_writes();
		random_phase(200);

		write_reg(dds_pkg::CFG_RAMP_UP, 102);
		write_reg(dds_pkg::CFG_RAMP_DOWN, 307);
		write_reg(dds_pkg::CFG_RAMP_TURN, 768);
		write_reg(dds_pkg::CFG_DEAD_LIN, int'($urandom_range(0, 255)));
		write_reg(dds_pkg::CFG_DEAD_TURN, int'($urandom_range(0, 255)));
		write_reg(dds_pkg::CFG_GAIN_P, int'($urandom_range(0, 65535)));
		write_reg(dds_pkg::CFG_GAIN_D, int'($urandom_range(0, 65535)));
		end_writes();
		random_phase(350);

		write_reg(dds_pkg::CFG_AUTO_MODE, 1);
		write_reg(dds_pkg::CFG_GAIN_P, 2560);
		write_reg(dds_pkg::CFG_GAIN_D, 77);
		end_writes();
		random_phase(350);

		if (errors == 0)
			$display("tb_diff_drive_setpoint_brake: clean");
		else
			$display("tb_diff_drive_setpoint_brake: errors");
		$finish;
	end

endmodule

### diff_drive_setpoint_brake.f
rtl/core/dds_pkg.sv
rtl/core/dds_ctrl.sv
rtl/core/dds_dp.sv
rtl/core/diff_drive_setpoint_brake.sv
tb/sv/tb_diff_drive_setpoint_brake.sv
